FILE: sv/accelerated_rotary_encoder_counter_core_macros.svh
// Assertion macros for the accelerated rotary encoder counter.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef ACCELERATED_ROTARY_ENCODER_COUNTER_CORE_MACROS_SVH
`define ACCELERATED_ROTARY_ENCODER_COUNTER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset.
`define ARECC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define ARECC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ARECC_ASSERT(lbl, prop, msg)
`define ARECC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: sv/arecc_pkg.sv
// Types and constants for the accelerated rotary encoder counter.
// Depends on nothing.
package arecc_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_EDGE  = 2'd1,
    OP_APPLY = 2'd2
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] channel;
    logic       phase_b;
    logic [7:0] value_in;
    logic [7:0] lower_bound;
    logic [7:0] upper_bound;
  } in_req_t;

  typedef struct packed {
    logic [7:0]        value_out;
    logic              applied;
    logic signed [15:0] pending_count;
  } out_rsp_t;

  // Register map, index of each register
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_POLARITY = 1'b1;

  localparam logic [7:0] DEBOUNCE_RESET = 8'd5;
  localparam int unsigned POL_BITS = 3;
  localparam logic [POL_BITS-1:0] POLARITY_RESET = 3'd6;

  localparam logic [31:0] SLOW_GAP_MS = 32'd109;
  localparam int unsigned SPEED_ENTRIES = 10;
  localparam logic [3:0] SPEED_LAST = 4'd9;
  localparam logic [3:0] SPEED_TABLE [SPEED_ENTRIES] = '{
    4'd10, 4'd10, 4'd5, 4'd5, 4'd2, 4'd2, 4'd2, 4'd1, 4'd1, 4'd1
  };
  // floor(x / 10) for x < 128 is (x * 205) >> 11
  localparam logic [7:0] DIV10_MUL = 8'd205;

endpackage

FILE: sv/accelerated_rotary_encoder_counter_core.sv
// Accelerated rotary encoder counter: top level, single module.
// Depends on arecc_pkg and accelerated_rotary_encoder_counter_core_macros.svh.
//
//  channel   direction  handshake                   payload
//  in        request    in_valid_i / in_stall_o     in_req_i  (in_req_t)
//  out       result     out_valid_o / out_stall_i   out_rsp_o (out_rsp_t)
//  config    APB write  psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// One request a cycle, sustained while the result side does not stall. A
// request lands in the input register at its accepting edge, is worked in one
// pass through the gap, step and apply logic as it moves on, and its result is
// held in the result register until it is taken. Reset clears time, edge times,
// pending counts and both valid flags at once; there is no clearing pass. A
// stalled result holds its register; the input register still drains into it
// once it is taken, so only the stall of the result side, never the wait for a
// result, holds back the next request.
`include "accelerated_rotary_encoder_counter_core_macros.svh"

module accelerated_rotary_encoder_counter_core import arecc_pkg::*; #(
  parameter int unsigned NUM_ENCODERS = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_req_t     in_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_rsp_t    out_rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IDX_W = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;
  localparam logic [3:0] NUM_ENC_L = 4'(NUM_ENCODERS);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0]          debounce_q;
  logic [POL_BITS-1:0] polarity_q;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
      polarity_q <= POLARITY_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_DEBOUNCE: debounce_q <= pwdata[7:0];
        REG_POLARITY: polarity_q <= pwdata[POL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DEBOUNCE: prdata = {24'd0, debounce_q};
      REG_POLARITY: prdata = {{(32 - POL_BITS){1'b0}}, polarity_q};
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register and pipeline control
  // ---------------------------------------------------------------------------
  logic    in_valid_q, in_valid_d;
  in_req_t req_q;
  logic    out_valid_q, out_valid_d;
  logic    advance;
  logic    in_accept;

  // Move the held request into the result register when that is free or
  // being taken this cycle.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_req_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Encoder state
  // ---------------------------------------------------------------------------
  logic [31:0]        time_q;
  logic [31:0]        last_edge_q [NUM_ENCODERS];
  logic signed [15:0] pending_q   [NUM_ENCODERS];

  logic [IDX_W+1:0]   chan_ext;
  logic [IDX_W-1:0]   ch_idx;
  logic               ch_valid;
  logic [31:0]        last_edge;
  logic signed [15:0] pending_cur;

  assign chan_ext    = {{IDX_W{1'b0}}, req_q.channel};
  assign ch_idx      = chan_ext[IDX_W-1:0];
  assign ch_valid    = {2'd0, req_q.channel} < NUM_ENC_L;
  assign last_edge   = ch_valid ? last_edge_q[ch_idx] : '0;
  assign pending_cur = ch_valid ? pending_q[ch_idx] : '0;

  // ---------------------------------------------------------------------------
  // Edge: gap, step size and saturating pending update
  // ---------------------------------------------------------------------------
  logic [31:0]        gap;
  logic               gap_slow;
  logic               gap_counts;
  logic [14:0]        div_prod;
  logic [3:0]         div_q;
  logic [3:0]         spd_idx;
  logic [3:0]         step_mag;
  logic               pol_bit;
  logic               positive;
  logic signed [16:0] pend_sum;
  logic signed [15:0] pend_edge;

  assign gap        = time_q - last_edge;
  assign gap_slow   = gap > SLOW_GAP_MS;
  assign gap_counts = gap >= {24'd0, debounce_q};
  assign div_prod   = 15'(gap[6:0]) * 15'(DIV10_MUL);
  assign div_q      = div_prod[14:11];

  always_comb begin
    // Gaps under 10 ms share the first entry with the 10..19 ms band.
    spd_idx = (div_q == 4'd0) ? 4'd0 : div_q - 4'd1;
    if (spd_idx > SPEED_LAST) begin
      spd_idx = SPEED_LAST;
    end
    step_mag = gap_slow ? 4'd1 : SPEED_TABLE[spd_idx];
  end

  // Channels beyond the polarity register have polarity 0.
  assign pol_bit  = ({2'd0, req_q.channel} < 4'(POL_BITS)) ? polarity_q[req_q.channel] : 1'b0;
  assign positive = req_q.phase_b ^ pol_bit;
  assign pend_sum = 17'(pending_cur) + (positive ? $signed({13'd0, step_mag})
                                                 : -$signed({13'd0, step_mag}));

  always_comb begin
    if (pend_sum > 17'sd32767) begin
      pend_edge = 16'sh7fff;
    end else if (pend_sum < -17'sd32768) begin
      pend_edge = 16'sh8000;
    end else begin
      pend_edge = pend_sum[15:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Apply: fold pending into the setting
  // ---------------------------------------------------------------------------
  logic signed [17:0] app_sum;
  logic signed [17:0] lo_s;
  logic signed [17:0] hi_s;
  logic [7:0]         app_val;

  assign app_sum = $signed({10'd0, req_q.value_in}) + 18'(pending_cur);
  assign lo_s    = $signed({10'd0, req_q.lower_bound});
  assign hi_s    = $signed({10'd0, req_q.upper_bound});

  always_comb begin
    if (req_q.channel == 2'd0) begin
      // Menu encoder wraps; the upper check wins when the bounds cross.
      if (app_sum > hi_s) begin
        app_val = 8'd0;
      end else if (app_sum < lo_s) begin
        app_val = req_q.upper_bound;
      end else begin
        app_val = app_sum[7:0];
      end
    end else begin
      if (app_sum > 18'sd255) begin
        app_val = 8'd255;
      end else if (app_sum < 18'sd0) begin
        app_val = 8'd0;
      end else begin
        app_val = app_sum[7:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Per-request decode
  // ---------------------------------------------------------------------------
  logic               time_inc;
  logic               edge_wr;
  logic               pend_wr;
  logic signed [15:0] pend_new;
  out_rsp_t           rsp_d;
  out_rsp_t           rsp_q;

  always_comb begin
    time_inc = 1'b0;
    edge_wr  = 1'b0;
    pend_wr  = 1'b0;
    pend_new = pending_cur;
    rsp_d.value_out = req_q.value_in;
    rsp_d.applied   = 1'b0;
    unique case (req_q.op)
      OP_TICK: time_inc = 1'b1;
      OP_EDGE: begin
        edge_wr = ch_valid;
        if (ch_valid && gap_counts) begin
          pend_wr  = 1'b1;
          pend_new = pend_edge;
        end
      end
      OP_APPLY: begin
        if (ch_valid && pending_cur != 16'sd0) begin
          pend_wr  = 1'b1;
          pend_new = '0;
          rsp_d.value_out = app_val;
          rsp_d.applied   = 1'b1;
        end
      end
      default: ;
    endcase
    rsp_d.pending_count = pend_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
      for (int i = 0; i < NUM_ENCODERS; i++) begin
        last_edge_q[i] <= '0;
        pending_q[i]   <= '0;
      end
    end else if (advance) begin
      if (time_inc) begin
        time_q <= time_q + 32'd1;
      end
      if (edge_wr) begin
        last_edge_q[ch_idx] <= time_q;
      end
      if (pend_wr) begin
        pending_q[ch_idx] <= pend_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ARECC_ASSERT_ALWAYS(a_stall_needs_held_req, in_stall_o |-> in_valid_q,
                       "input stalled with no request held")
  `ARECC_ASSERT(a_applied_clears, out_valid_o && out_rsp_o.applied |->
                out_rsp_o.pending_count == 16'sd0, "apply left a pending count")
  `ARECC_ASSERT(a_time_tick, advance && req_q.op == OP_TICK |=>
                time_q == $past(time_q) + 32'd1, "tick did not advance time")
  `ARECC_ASSERT(a_time_hold, advance && req_q.op != OP_TICK |=>
                time_q == $past(time_q), "time moved without a tick")
  `ARECC_ASSERT(a_result_source, $rose(out_valid_o) |-> $past(advance),
                "result appeared without a request moving")

endmodule
